/* src/k_transaction_max_profit_defines.svh */
// Assertion macros shared by the k-transaction profit block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef K_TRANSACTION_MAX_PROFIT_DEFINES_SVH
`define K_TRANSACTION_MAX_PROFIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ktmp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KTMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ktmp: next-cycle check failed");

`endif

/* src/ktmp_pkg.sv */
// Types and constants for the k-transaction profit block.
// No dependencies; used by ktmp_slot_upd and k_transaction_max_profit.
`timescale 1ns / 1ps

package ktmp_pkg;

  localparam int unsigned PriceInW  = 16;
  localparam int unsigned ProfitW   = 31;
  localparam int unsigned HoldW     = 32;
  localparam int unsigned CfgW      = 7;

  localparam logic [ProfitW-1:0]       ProfitMax = {ProfitW{1'b1}};
  localparam logic signed [HoldW-1:0]  HoldReset = {1'b1, {(HoldW-1){1'b0}}};

  // One transaction slot: best value while holding, best value after selling.
  typedef struct packed {
    logic signed [HoldW-1:0] hold;
    logic [ProfitW-1:0]      sold;
  } slot_t;

  localparam slot_t SlotReset = '{hold: HoldReset, sold: '0};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

endpackage

/* src/ktmp_slot_upd.sv */
// Update of one transaction slot for one price: sell and buy recurrences.
// Depends on ktmp_pkg for the slot type and the profit limit.
`timescale 1ns / 1ps

module ktmp_slot_upd #(
  parameter int unsigned PW = 16
) (
  input  ktmp_pkg::slot_t                 old_i,
  input  logic [ktmp_pkg::ProfitW-1:0]    prev_sold_i,
  input  logic [PW-1:0]                   price_i,
  output ktmp_pkg::slot_t                 new_o
);

  logic signed [32:0] price_ext;
  logic signed [32:0] hold_ext;
  logic signed [32:0] sold_ext;
  logic signed [32:0] sale;
  logic signed [32:0] sale_sat;
  logic signed [32:0] buy;

  assign price_ext = $signed({{(33-PW){1'b0}}, price_i});
  assign hold_ext  = $signed({old_i.hold[31], old_i.hold});
  assign sold_ext  = $signed({2'b00, old_i.sold});

  assign sale     = hold_ext + price_ext;
  assign sale_sat = (sale > $signed({2'b00, ktmp_pkg::ProfitMax})) ?
                    $signed({2'b00, ktmp_pkg::ProfitMax}) : sale;
  // The previous slot's sold value is never negative, so the buy stays above minus infinity.
  assign buy      = $signed({2'b00, prev_sold_i}) - price_ext;

  always_comb begin
    new_o.sold = (sale_sat > sold_ext) ? sale_sat[30:0] : old_i.sold;
    new_o.hold = (buy > hold_ext) ? buy[31:0] : old_i.hold;
  end

endmodule

/* src/k_transaction_max_profit.sv */
// Top level of the k-transaction maximum profit block: slot memory, sequencer, output register.
// Depends on ktmp_pkg, ktmp_slot_upd and k_transaction_max_profit_defines.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | price_i, last_price_i
//  out     | output    | out_valid_o / out_stall_i | best_profit_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | max_transactions_i
//
// A price that is not last walks the first L slots, L being the limit clipped to MAX_SLOTS:
// one slot per cycle goes through the single-port-read slot memory, and each slot is
// written back from the registered read data.
// A last price sweeps all MAX_SLOTS entries (evaluating active slots for the best profit and
// clearing every one), then loads the output register.
// After reset a clearing pass over all MAX_SLOTS entries runs before the first price is taken.
// A stalled output holds the result; a new result waits to be loaded while the old one is untaken.
`timescale 1ns / 1ps
`include "k_transaction_max_profit_defines.svh"

module k_transaction_max_profit #(
  parameter int unsigned MAX_SLOTS  = 64,
  parameter int unsigned PRICE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ktmp_pkg::CfgW-1:0]     max_transactions_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ktmp_pkg::PriceInW-1:0] price_i,
  input  logic                          last_price_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ktmp_pkg::ProfitW-1:0]  best_profit_o
);

  localparam int unsigned PW = (PRICE_BITS < ktmp_pkg::PriceInW) ? PRICE_BITS :
                               ktmp_pkg::PriceInW;
  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam logic [CW-1:0] SlotsCnt = CW'(MAX_SLOTS);
  localparam logic [CW-1:0] LastSlot = CW'(MAX_SLOTS - 1);

  ktmp_pkg::state_e state_q, state_d;

  logic [ktmp_pkg::CfgW-1:0]    cfg_q, cfg_d;
  logic [CW-1:0]                rd_cnt_q, rd_cnt_d;
  logic                         s1_valid_q, s1_valid_d;
  logic [CW-1:0]                s1_idx_q, s1_idx_d;
  logic [PW-1:0]                price_q, price_d;
  logic                         last_q, last_d;
  logic [CW-1:0]                lim_q, lim_d;
  logic [CW-1:0]                end_q, end_d;
  logic [ktmp_pkg::ProfitW-1:0] prev_sold_q, prev_sold_d;
  logic [ktmp_pkg::ProfitW-1:0] best_q, best_d;
  logic                         out_valid_q, out_valid_d;
  logic [ktmp_pkg::ProfitW-1:0] best_profit_q, best_profit_d;

  ktmp_pkg::slot_t mem_q [MAX_SLOTS];
  ktmp_pkg::slot_t slot_rd_q;
  ktmp_pkg::slot_t slot_new;
  ktmp_pkg::slot_t mem_wdata;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;

  logic in_acc;
  logic out_free;
  logic walk_done;
  logic slot_active;
  logic [CW-1:0] cfg_lim;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ktmp_pkg::ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign best_profit_o = best_profit_q;

  assign cfg_d   = cfg_valid_i ? max_transactions_i : cfg_q;
  assign cfg_lim = (32'(cfg_q) > MAX_SLOTS) ? SlotsCnt : CW'(cfg_q);

  assign walk_done   = (rd_cnt_q == end_q) && !s1_valid_q;
  assign slot_active = (s1_idx_q < lim_q);

  ktmp_slot_upd #(
    .PW (PW)
  ) u_slot_upd (
    .old_i       (slot_rd_q),
    .prev_sold_i (prev_sold_q),
    .price_i     (price_q),
    .new_o       (slot_new)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ktmp_pkg::ST_CLEAR: begin
        if (rd_cnt_q == LastSlot) begin
          state_d = ktmp_pkg::ST_IDLE;
        end
      end
      ktmp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = ktmp_pkg::ST_WALK;
        end
      end
      ktmp_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = last_q ? ktmp_pkg::ST_EMIT : ktmp_pkg::ST_IDLE;
        end
      end
      ktmp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = ktmp_pkg::ST_IDLE;
        end
      end
      default: state_d = ktmp_pkg::ST_CLEAR;
    endcase
  end

  // Datapath control and memory access.
  always_comb begin
    rd_cnt_d      = rd_cnt_q;
    s1_valid_d    = 1'b0;
    s1_idx_d      = s1_idx_q;
    price_d       = price_q;
    last_d        = last_q;
    lim_d         = lim_q;
    end_d         = end_q;
    prev_sold_d   = prev_sold_q;
    best_d        = best_q;
    best_profit_d = best_profit_q;
    out_valid_d   = out_valid_q && out_stall_i;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = s1_idx_q[AW-1:0];
    mem_raddr     = rd_cnt_q[AW-1:0];
    mem_wdata     = ktmp_pkg::SlotReset;

    case (state_q)
      ktmp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_cnt_q[AW-1:0];
        rd_cnt_d  = (rd_cnt_q == LastSlot) ? '0 : rd_cnt_q + 1'b1;
      end
      ktmp_pkg::ST_IDLE: begin
        if (in_acc) begin
          price_d     = price_i[PW-1:0];
          last_d      = last_price_i;
          lim_d       = cfg_lim;
          end_d       = last_price_i ? SlotsCnt : cfg_lim;
          rd_cnt_d    = '0;
          prev_sold_d = '0;
          best_d      = '0;
        end
      end
      ktmp_pkg::ST_WALK: begin
        if (rd_cnt_q != end_q) begin
          mem_re     = 1'b1;
          s1_valid_d = 1'b1;
          s1_idx_d   = rd_cnt_q;
          rd_cnt_d   = rd_cnt_q + 1'b1;
        end
        if (s1_valid_q) begin
          // The slot above needs this slot's sold value from before this price.
          prev_sold_d = slot_rd_q.sold;
          mem_we      = 1'b1;
          if (last_q) begin
            mem_wdata = ktmp_pkg::SlotReset;
          end else begin
            mem_wdata = slot_active ? slot_new : slot_rd_q;
          end
          if (slot_active && (slot_new.sold > best_q)) begin
            best_d = slot_new.sold;
          end
        end
      end
      ktmp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          best_profit_d = best_q;
        end
      end
      default: begin
        rd_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ktmp_pkg::ST_CLEAR;
      cfg_q       <= ktmp_pkg::CfgW'(1);
      rd_cnt_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      rd_cnt_q    <= rd_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q      <= s1_idx_d;
    price_q       <= price_d;
    last_q        <= last_d;
    lim_q         <= lim_d;
    end_q         <= end_d;
    prev_sold_q   <= prev_sold_d;
    best_q        <= best_d;
    best_profit_q <= best_profit_d;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      slot_rd_q <= mem_q[mem_raddr];
    end
  end

  `KTMP_ASSERT_NXT(a_accept_then_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `KTMP_ASSERT_NXT(a_result_from_emit, clk_i, rst_ni,
                   !out_valid_q && (state_q != ktmp_pkg::ST_EMIT), !out_valid_q)
  `KTMP_ASSERT_IMP(a_slot_in_range, clk_i, rst_ni, s1_valid_q, s1_idx_q < end_q)
  `KTMP_ASSERT_IMP(a_walk_end_is_limit, clk_i, rst_ni,
                   (state_q == ktmp_pkg::ST_WALK) && !last_q, end_q == lim_q)

endmodule

/* sim/k_transaction_max_profit_tb.sv */
// Self-checking testbench for k_transaction_max_profit: price sequences with random pacing
// on both channels, checked against a behavioral model of the per-slot profit tables.
// Depends on ktmp_pkg and the k_transaction_max_profit RTL.
`timescale 1ns / 1ps

module k_transaction_max_profit_tb;

  localparam int unsigned MAX_SLOTS   = 64;
  localparam int unsigned PRICE_BITS  = 16;
  localparam int          RAND_ITEMS  = 1000;
  // Longest block activity after the last transfer: a last price sweeps all slots.
  localparam int          DRAIN       = MAX_SLOTS + 16;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam longint      NEG_INF     = -64'sd2147483648;
  localparam longint      PROFIT_MAX  = 64'sd2147483647;

  typedef struct packed {
    logic [ktmp_pkg::PriceInW-1:0] price;
    logic                          last;
  } price_item_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_BAND,
    PAT_RISE,
    PAT_FALL,
    PAT_SWING
  } price_pat_e;

  logic                          clk_i              = 1'b0;
  logic                          rst_ni             = 1'b0;
  logic                          cfg_valid_i        = 1'b0;
  logic                          cfg_ready_o;
  logic [ktmp_pkg::CfgW-1:0]     max_transactions_i = '0;
  logic                          in_valid_i         = 1'b0;
  logic                          in_stall_o;
  logic [ktmp_pkg::PriceInW-1:0] price_i            = '0;
  logic                          last_price_i       = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i        = 1'b0;
  logic [ktmp_pkg::ProfitW-1:0]  best_profit_o;

  // Model state: entry j-1 holds transaction slot j.
  longint                    hold_tbl [MAX_SLOTS];
  longint                    sold_tbl [MAX_SLOTS];
  logic [ktmp_pkg::CfgW-1:0] txn_limit = 7'd1;

  price_item_t                  price_q[$];
  logic [ktmp_pkg::ProfitW-1:0] profit_q[$];

  int  pushed_cnt    = 0;
  int  accepted_cnt  = 0;
  int  results_seen  = 0;
  int  mismatch_cnt  = 0;
  int  limit_writes  = 0;
  int  cycle_cnt     = 0;
  int  in_gap        = 0;
  int  out_hold      = 0;
  int  nxt_hold;
  bit  calm          = 1'b0;
  logic nxt_valid;
  price_item_t drv_item;
  logic [ktmp_pkg::ProfitW-1:0] want_profit;

  k_transaction_max_profit #(
    .MAX_SLOTS (MAX_SLOTS),
    .PRICE_BITS(PRICE_BITS)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .max_transactions_i(max_transactions_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .price_i           (price_i),
    .last_price_i      (last_price_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .best_profit_o     (best_profit_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_profit_tables();
    int j;
    for (j = 0; j < MAX_SLOTS; j++) begin
      hold_tbl[j] = NEG_INF;
      sold_tbl[j] = 0;
    end
  endfunction

  // Applies one price to every active slot; on a last price queues the best profit and clears the tables.
  function automatic void update_profit_tables(input logic [ktmp_pkg::PriceInW-1:0] price,
                                               input logic last);
    longint p, sale, buy, prev_sold, best;
    int     k, j;
    p = longint'(price & ((64'd1 << PRICE_BITS) - 1));
    k = (txn_limit > MAX_SLOTS) ? MAX_SLOTS : int'(txn_limit);
    // Walking down keeps slot j-1 at its value from the previous price.
    for (j = k; j >= 1; j--) begin
      prev_sold = (j >= 2) ? sold_tbl[j-2] : 0;
      sale = hold_tbl[j-1] + p;
      if (sale > PROFIT_MAX) sale = PROFIT_MAX;
      if (sale > sold_tbl[j-1]) sold_tbl[j-1] = sale;
      buy = prev_sold - p;
      if (buy > hold_tbl[j-1]) hold_tbl[j-1] = buy;
    end
    if (last) begin
      best = 0;
      for (j = 0; j < k; j++) begin
        if (sold_tbl[j] > best) best = sold_tbl[j];
      end
      if (best > PROFIT_MAX) best = PROFIT_MAX;
      profit_q.push_back(best[ktmp_pkg::ProfitW-1:0]);
      clear_profit_tables();
    end
  endfunction

  // Price channel driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        update_profit_tables(price_i, last_price_i);
        accepted_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (price_q.size() > 0) begin
          drv_item = price_q.pop_front();
          price_i <= drv_item.price;
          last_price_i <= drv_item.last;
          nxt_valid = 1'b1;
          in_gap = calm ? 0 : $urandom_range(0, 9);
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      nxt_hold = out_hold;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (profit_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected profit result %0d with nothing pending", best_profit_o);
        end else begin
          want_profit = profit_q.pop_front();
          if (best_profit_o !== want_profit) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("best_profit mismatch: expected %0d, got %0d", want_profit,
                       best_profit_o);
          end
        end
        nxt_hold = calm ? 0 : $urandom_range(0, 9);
      end else if (out_valid_o && out_hold != 0) begin
        nxt_hold = out_hold - 1;
      end
      out_hold = nxt_hold;
      out_stall_i <= (nxt_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_price(input logic [ktmp_pkg::PriceInW-1:0] price, input logic last);
    price_item_t itm;
    itm.price = price;
    itm.last  = last;
    price_q.push_back(itm);
    pushed_cnt++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (accepted_cnt != pushed_cnt || profit_q.size() != 0);
  endtask

  task automatic write_limit(input logic [ktmp_pkg::CfgW-1:0] value);
    wait_idle();
    // A non-last price yields no result, so the block may still be walking slots.
    repeat (DRAIN) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    max_transactions_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    txn_limit = value;
    limit_writes++;
  endtask

  // Queues one sequence; an open one is left without its last price.
  task automatic send_sequence(input int len, input price_pat_e pat, input bit open);
    int  i, base, step;
    logic [ktmp_pkg::PriceInW-1:0] p;
    base = $urandom_range(0, 65535);
    step = $urandom_range(0, 600);
    for (i = 0; i < len; i++) begin
      case (pat)
        PAT_RANDOM: p = 16'($urandom_range(0, 65535));
        PAT_BAND:   p = 16'(((base > 64535) ? 64535 : base) + $urandom_range(0, 1000));
        PAT_RISE:   p = (base + i * step > 65535) ? 16'hFFFF : 16'(base + i * step);
        PAT_FALL:   p = (base < i * step) ? 16'h0000 : 16'(base - i * step);
        default:    p = (i % 2 == 0) ? 16'($urandom_range(0, 255)) :
                                       16'($urandom_range(65280, 65535));
      endcase
      push_price(p, !open && (i == len - 1));
    end
  endtask

  initial begin
    int   random_items, nseq, s, len, r;
    logic [ktmp_pkg::CfgW-1:0] lim;
    bit   open;

    clear_profit_tables();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting at the reset limit of one transaction.
    push_price(16'd10, 1'b0);
    push_price(16'd5, 1'b0);
    push_price(16'd20, 1'b1);
    push_price(16'hFFFF, 1'b1);
    push_price(16'h0000, 1'b0);
    push_price(16'hFFFF, 1'b1);
    push_price(16'hFFFF, 1'b0);
    push_price(16'h0000, 1'b1);
    write_limit(7'd0);
    push_price(16'd3, 1'b0);
    push_price(16'd9, 1'b1);
    push_price(16'h0000, 1'b0);
    push_price(16'hFFFF, 1'b1);
    // A limit past the slot count clips to the slot count.
    write_limit(7'd127);
    for (int i = 0; i < 7; i++) push_price((i % 2 == 0) ? 16'hFFFF : 16'h0000, i == 6);
    // Limit changed in the middle of a sequence.
    write_limit(7'd2);
    push_price(16'd100, 1'b0);
    push_price(16'd50, 1'b0);
    write_limit(7'd64);
    push_price(16'd200, 1'b0);
    push_price(16'd10, 1'b0);
    push_price(16'd300, 1'b1);
    write_limit(7'd65);
    push_price(16'd7, 1'b0);
    push_price(16'd1, 1'b0);
    push_price(16'd9, 1'b1);

    random_items = 0;
    while (random_items < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       lim = 7'd0;
        1:       lim = 7'($urandom_range(9, 127));
        2:       lim = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd64;
        default: lim = 7'($urandom_range(1, 8));
      endcase
      write_limit(lim);
      calm = ($urandom_range(0, 3) == 0);
      nseq = $urandom_range(1, 5);
      for (s = 0; s < nseq; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        open = (s == nseq - 1) && ($urandom_range(0, 4) == 0);
        send_sequence(len, price_pat_e'($urandom_range(0, 4)), open);
        random_items += len;
      end
    end
    // Close any sequence left open by the last phase.
    push_price(16'($urandom_range(0, 65535)), 1'b1);

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    if (profit_q.size() != 0) begin
      $display("%0d profit results never arrived", profit_q.size());
      mismatch_cnt += profit_q.size();
    end
    $display("Sent %0d prices under %0d limit settings; %0d profit results checked.",
             accepted_cnt, limit_writes + 1, results_seen);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatch_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
